// ----- hw/rtl/alu8f_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types and constants of the 8-bit CPU execute unit: the operation
// codes, the flag bit positions, the decimal adjust constants and the
// request and response item structures.
// ----------------------------------------------------------------------------
package alu8f_pkg;

   // Operation codes.
   localparam logic [4:0] MODE_ADD     = 5'd0;
   localparam logic [4:0] MODE_ADC     = 5'd1;
   localparam logic [4:0] MODE_SUB     = 5'd2;
   localparam logic [4:0] MODE_SBC     = 5'd3;
   localparam logic [4:0] MODE_AND     = 5'd4;
   localparam logic [4:0] MODE_XOR     = 5'd5;
   localparam logic [4:0] MODE_OR      = 5'd6;
   localparam logic [4:0] MODE_CP      = 5'd7;
   localparam logic [4:0] MODE_INC     = 5'd8;
   localparam logic [4:0] MODE_DEC     = 5'd9;
   localparam logic [4:0] MODE_RLC     = 5'd10;
   localparam logic [4:0] MODE_RRC     = 5'd11;
   localparam logic [4:0] MODE_RL      = 5'd12;
   localparam logic [4:0] MODE_RR      = 5'd13;
   localparam logic [4:0] MODE_SLA     = 5'd14;
   localparam logic [4:0] MODE_SRA     = 5'd15;
   localparam logic [4:0] MODE_SWAP    = 5'd16;
   localparam logic [4:0] MODE_SRL     = 5'd17;
   localparam logic [4:0] MODE_BIT     = 5'd18;
   localparam logic [4:0] MODE_RES     = 5'd19;
   localparam logic [4:0] MODE_SET     = 5'd20;
   localparam logic [4:0] MODE_DAA     = 5'd21;
   localparam logic [4:0] MODE_CPL     = 5'd22;
   localparam logic [4:0] MODE_SCF     = 5'd23;
   localparam logic [4:0] MODE_CCF     = 5'd24;
   localparam logic [4:0] MODE_ADD16   = 5'd25;
   localparam logic [4:0] MODE_SP_PLUS = 5'd26;
   localparam logic [4:0] MODE_RLCA    = 5'd27;
   localparam logic [4:0] MODE_RRCA    = 5'd28;
   localparam logic [4:0] MODE_RLA     = 5'd29;
   localparam logic [4:0] MODE_RRA     = 5'd30;
   localparam logic [4:0] MODE_UNUSED  = 5'd31;

   // Flag bit positions in the 4-bit flag word.
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // Decimal adjust constants.
   localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
   localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
   localparam logic [7:0] DAA_ADJ_LO   = 8'h06;

   // One request item.
   typedef struct packed {
      logic [4:0]  mode;
      logic [7:0]  accum;
      logic [7:0]  operand;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } req_type;

   // One response item.
   typedef struct packed {
      logic [7:0]  result_byte;
      logic [15:0] result_word;
      logic [3:0]  flags_out;
   } rsp_type;

endpackage

// ----- hw/rtl/alu8f_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_exec
// Combinational datapath of the execute unit: byte ALU, shifter, bit
// operations, decimal adjust and the two 16-bit adds, with flag generation.
// ----------------------------------------------------------------------------
module alu8f_exec (
   input  alu8f_pkg::req_type req,
   output alu8f_pkg::rsp_type rsp
);

   // Rotate or shift by one code: RLC RRC RL RR SLA SRA SWAP SRL.
   // Returns the carry out above the result byte.
   function automatic logic [8:0] shift_op(input logic [2:0] sel,
                                           input logic [7:0] v,
                                           input logic cin);
      logic [8:0] res;
      unique case (sel)
         3'd0: res = {v[7], v[6:0], v[7]};
         3'd1: res = {v[0], v[0], v[7:1]};
         3'd2: res = {v[7], v[6:0], cin};
         3'd3: res = {v[0], cin, v[7:1]};
         3'd4: res = {v[7], v[6:0], 1'b0};
         3'd5: res = {v[0], v[7], v[7:1]};
         3'd6: res = {1'b0, v[3:0], v[7:4]};
         3'd7: res = {v[0], 1'b0, v[7:1]};
      endcase
      return res;
   endfunction

   logic [7:0]  a;
   logic [7:0]  v;
   logic [3:0]  f;
   logic        cf;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  sum_lo;
   logic [8:0]  diff9;
   logic [4:0]  diff_lo;
   logic [7:0]  bit_mask;
   logic [4:0]  cb_sel;
   logic [4:0]  acc_sel;
   logic [8:0]  cb_out;
   logic [8:0]  acc_out;
   logic [7:0]  daa_adj;
   logic        daa_c;
   logic [7:0]  daa_res;
   logic [16:0] add16_sum;
   logic [12:0] add16_lo;
   logic [15:0] sp_sum;
   logic [4:0]  sp_lo;
   logic [8:0]  sp_byte;
   logic [7:0]  rb;
   logic [15:0] rw;
   logic [3:0]  fo;

   assign a  = req.accum;
   assign v  = req.operand;
   assign f  = req.flags_in;
   assign cf = f[alu8f_pkg::FLAG_C];

   // Carry in for ADC and SBC only.
   assign cin = ((req.mode == alu8f_pkg::MODE_ADC) || (req.mode == alu8f_pkg::MODE_SBC))
                ? cf : 1'b0;

   // Byte add and subtract with nibble carries.
   assign sum9    = {1'b0, a} + {1'b0, v} + {8'd0, cin};
   assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
   assign diff9   = {1'b0, a} - {1'b0, v} - {8'd0, cin};
   assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

   // Single-bit mask for BIT, RES and SET.
   assign bit_mask = 8'd1 << req.bit_index;

   // Shifter for the CB group on the operand and the accumulator rotates.
   assign cb_sel  = req.mode - alu8f_pkg::MODE_RLC;
   assign acc_sel = req.mode - alu8f_pkg::MODE_RLCA;
   assign cb_out  = shift_op(cb_sel[2:0], v, cf);
   assign acc_out = shift_op(acc_sel[2:0], a, cf);

   // Decimal adjust after an add or a subtract.
   always_comb begin
      daa_adj = 8'd0;
      daa_c   = cf;
      if (!f[alu8f_pkg::FLAG_N]) begin
         if (cf || (a > alu8f_pkg::DAA_HI_LIMIT)) begin
            daa_adj = daa_adj | alu8f_pkg::DAA_ADJ_HI;
            daa_c   = 1'b1;
         end
         if (f[alu8f_pkg::FLAG_H] || (a[3:0] > alu8f_pkg::DAA_LO_LIMIT)) begin
            daa_adj = daa_adj | alu8f_pkg::DAA_ADJ_LO;
         end
         daa_res = a + daa_adj;
      end else begin
         if (cf) begin
            daa_adj = daa_adj | alu8f_pkg::DAA_ADJ_HI;
         end
         if (f[alu8f_pkg::FLAG_H]) begin
            daa_adj = daa_adj | alu8f_pkg::DAA_ADJ_LO;
         end
         daa_res = a - daa_adj;
      end
   end

   // 16-bit adds: HL plus a pair, and SP plus a signed byte offset.
   assign add16_sum = {1'b0, req.word_a} + {1'b0, req.word_b};
   assign add16_lo  = {1'b0, req.word_a[11:0]} + {1'b0, req.word_b[11:0]};
   assign sp_sum    = req.word_a + {{8{v[7]}}, v};
   assign sp_lo     = {1'b0, req.word_a[3:0]} + {1'b0, v[3:0]};
   assign sp_byte   = {1'b0, req.word_a[7:0]} + {1'b0, v};

   // Result selection and flags.
   always_comb begin
      rb = a;
      rw = 16'd0;
      fo = f;
      unique case (req.mode)
         alu8f_pkg::MODE_ADD, alu8f_pkg::MODE_ADC: begin
            rb = sum9[7:0];
            fo = {(sum9[7:0] == 8'd0), 1'b0, sum_lo[4], sum9[8]};
         end
         alu8f_pkg::MODE_SUB, alu8f_pkg::MODE_SBC: begin
            rb = diff9[7:0];
            fo = {(diff9[7:0] == 8'd0), 1'b1, diff_lo[4], diff9[8]};
         end
         alu8f_pkg::MODE_CP: begin
            fo = {(diff9[7:0] == 8'd0), 1'b1, diff_lo[4], diff9[8]};
         end
         alu8f_pkg::MODE_AND: begin
            rb = a & v;
            fo = {((a & v) == 8'd0), 1'b0, 1'b1, 1'b0};
         end
         alu8f_pkg::MODE_XOR: begin
            rb = a ^ v;
            fo = {((a ^ v) == 8'd0), 3'b000};
         end
         alu8f_pkg::MODE_OR: begin
            rb = a | v;
            fo = {((a | v) == 8'd0), 3'b000};
         end
         alu8f_pkg::MODE_INC: begin
            rb = v + 8'd1;
            fo = {(v == 8'hFF), 1'b0, (v[3:0] == 4'hF), cf};
         end
         alu8f_pkg::MODE_DEC: begin
            rb = v - 8'd1;
            fo = {(v == 8'd1), 1'b1, (v[3:0] == 4'h0), cf};
         end
         alu8f_pkg::MODE_RLC, alu8f_pkg::MODE_RRC, alu8f_pkg::MODE_RL,
         alu8f_pkg::MODE_RR, alu8f_pkg::MODE_SLA, alu8f_pkg::MODE_SRA,
         alu8f_pkg::MODE_SWAP, alu8f_pkg::MODE_SRL: begin
            rb = cb_out[7:0];
            fo = {(cb_out[7:0] == 8'd0), 2'b00, cb_out[8]};
         end
         alu8f_pkg::MODE_BIT: begin
            fo = {((v & bit_mask) == 8'd0), 1'b0, 1'b1, cf};
         end
         alu8f_pkg::MODE_RES: begin
            rb = v & ~bit_mask;
         end
         alu8f_pkg::MODE_SET: begin
            rb = v | bit_mask;
         end
         alu8f_pkg::MODE_DAA: begin
            rb = daa_res;
            fo = {(daa_res == 8'd0), f[alu8f_pkg::FLAG_N], 1'b0, daa_c};
         end
         alu8f_pkg::MODE_CPL: begin
            rb = ~a;
            fo = {f[alu8f_pkg::FLAG_Z], 1'b1, 1'b1, cf};
         end
         alu8f_pkg::MODE_SCF: begin
            fo = {f[alu8f_pkg::FLAG_Z], 2'b00, 1'b1};
         end
         alu8f_pkg::MODE_CCF: begin
            fo = {f[alu8f_pkg::FLAG_Z], 2'b00, ~cf};
         end
         alu8f_pkg::MODE_ADD16: begin
            rw = add16_sum[15:0];
            fo = {f[alu8f_pkg::FLAG_Z], 1'b0, add16_lo[12], add16_sum[16]};
         end
         alu8f_pkg::MODE_SP_PLUS: begin
            rw = sp_sum;
            fo = {2'b00, sp_lo[4], sp_byte[8]};
         end
         alu8f_pkg::MODE_RLCA, alu8f_pkg::MODE_RRCA, alu8f_pkg::MODE_RLA,
         alu8f_pkg::MODE_RRA: begin
            rb = acc_out[7:0];
            fo = {3'b000, acc_out[8]};
         end
         default: begin
            // The unused code passes the accumulator and flags through.
            rb = a;
            rw = 16'd0;
            fo = f;
         end
      endcase
   end

   assign rsp.result_byte = rb;
   assign rsp.result_word = rw;
   assign rsp.flags_out   = fo;

endmodule

// ----- hw/rtl/eight_bit_cpu_alu_with_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// Execute unit of an 8-bit accumulator CPU with Z N H C flags, registered
// at its input and its output.
// ----------------------------------------------------------------------------
// The unit accepts one item in every clock cycle while req_stall is low, and
// returns exactly one response item for each, in order. An accepted item is
// held in the input register while the combinational datapath computes its
// result, which is then captured in the response register and presented on
// rsp_data until it is taken. A one-entry skid register behind the response
// register absorbs the item in flight when rsp_stall is raised; req_stall is
// raised only once that skid entry is in use and the input register cannot
// move, and it depends on registers only.
module eight_bit_cpu_alu_with_flags (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  alu8f_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output alu8f_pkg::rsp_type rsp_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   alu8f_pkg::req_type s1_data_ff;
   logic               req_accept;
   logic               s1_move;
   logic               out_ready;
   alu8f_pkg::rsp_type exec_rsp;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   alu8f_pkg::rsp_type rsp_data_ff;
   alu8f_pkg::rsp_type rsp_data_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   alu8f_pkg::rsp_type skid_data_ff;
   alu8f_pkg::rsp_type skid_data_in;
   logic               out_free;

   // Input stage handshake: the stage moves whenever the skid entry is free.
   assign out_ready  = ~skid_valid_ff;
   assign s1_move    = s1_valid_ff & out_ready;
   assign req_stall  = s1_valid_ff & ~out_ready;
   assign req_accept = req_valid & ~req_stall;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_move);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
   end

   // Datapath.
   alu8f_exec u_exec (
      .req (s1_data_ff),
      .rsp (exec_rsp)
   );

   // Output register and skid entry. The output register is free when it is
   // empty or its item is taken in this cycle; it then refills from the skid
   // entry first, so order is kept.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = s1_move;
            rsp_data_in  = exec_rsp;
         end
      end else if (s1_move) begin
         skid_valid_in = 1'b1;
         skid_data_in  = exec_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // The skid entry is only ever used behind a held response.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while response register is empty");

   // An accepted item always lands in the input register.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item not held in input register");

   // An input item that cannot move keeps its contents.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("blocked input item was lost or changed");

   // A result that arrives behind a stalled response goes into the skid entry.
   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && s1_move) |=> skid_valid_ff)
      else $error("result in flight dropped under response stall");
`endif

endmodule
